/* rtl/le_oob_ad_parser_assert.svh */
// le_oob_ad_parser_assert.svh: assertion macros shared by the parser RTL.
// Expects clk and rst_n in the module that includes it; define NO_ASSERTIONS to drop them.
`ifndef LE_OOB_AD_PARSER_ASSERT_SVH
`define LE_OOB_AD_PARSER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define LEOOB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("le_oob_ad_parser: assertion violated");
// next-cycle implication
`define LEOOB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("le_oob_ad_parser: assertion violated");
`else
`define LEOOB_ASSERT_IMP(lbl, ante, cons)
`define LEOOB_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

/* rtl/leoob_pkg.sv */
// leoob_pkg: shared constants and types of the LE OOB AD parser.
// No dependencies; imported by leoob_parse, leoob_emit and le_oob_ad_parser.
package leoob_pkg;

  localparam int NAME_CAP   = 32;
  localparam int NAME_KEEP  = ((NAME_CAP - 1) < 31) ? (NAME_CAP - 1) : 31;
  localparam int NAME_BYTES = 32;
  localparam int NUM_WORDS  = 9;
  localparam int CNT_W      = $clog2(NUM_WORDS);

  typedef struct packed {
    logic [47:0]             addr;
    logic                    atype;
    logic [7:0]              role;
    logic [15:0]             app;
    logic [NAME_BYTES*8-1:0] name;
    logic [4:0]              nlen;
    logic [127:0]            conf;
    logic [127:0]            rnd;
    logic [5:0]              flags;
  } kept_t;

  typedef struct packed {
    logic  valid;
    kept_t data;
  } snap_load_t;

endpackage

/* rtl/leoob_parse.sv */
// leoob_parse: length-type-value walker, stage buffer and kept record.
// Depends on leoob_pkg and le_oob_ad_parser_assert.svh.
`include "le_oob_ad_parser_assert.svh"

module leoob_parse import leoob_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_take,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output snap_load_t load
);

  localparam logic [7:0] AD_NAME_SHORT = 8'h08;
  localparam logic [7:0] AD_NAME_FULL  = 8'h09;
  localparam logic [7:0] AD_APPEARANCE = 8'h19;
  localparam logic [7:0] AD_ADDR       = 8'h1B;
  localparam logic [7:0] AD_ROLE       = 8'h1C;
  localparam logic [7:0] AD_CONFIRM    = 8'h22;
  localparam logic [7:0] AD_RANDOM     = 8'h23;
  localparam logic [7:0] ATYPE_MASK    = 8'h01;

  localparam int STAGE_DEPTH = 32;
  localparam int STAGE_AW    = $clog2(STAGE_DEPTH);

  localparam int FLAG_ADDR = 0;
  localparam int FLAG_ROLE = 1;
  localparam int FLAG_APP  = 2;
  localparam int FLAG_NAME = 3;
  localparam int FLAG_CONF = 4;
  localparam int FLAG_RND  = 5;

  typedef enum logic [2:0] {
    PH_LEN   = 3'b001,
    PH_TYPE  = 3'b010,
    PH_VALUE = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic [7:0]  stage_r   [STAGE_DEPTH];
  logic [7:0]  stage_nxt [STAGE_DEPTH];
  kept_t       kept_r, kept_nxt;
  logic        commit;
  logic        clear;

  assign clear = byte_take && last_byte;

  // walk the structure and stage the value byte
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    type_nxt  = type_r;
    pos_nxt   = pos_r;
    stage_nxt = stage_r;
    commit    = 1'b0;
    if (byte_take) begin
      unique case (phase_r)
        PH_LEN: begin
          if (data_byte != 8'd0) begin
            left_nxt  = data_byte;
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt = data_byte;
          pos_nxt  = '0;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            commit    = 1'b1;
            phase_nxt = PH_LEN;
          end else begin
            phase_nxt = PH_VALUE;
          end
        end
        PH_VALUE: begin
          if (pos_r < STAGE_DEPTH) stage_nxt[pos_r[STAGE_AW-1:0]] = data_byte;
          pos_nxt  = pos_r + 8'd1;
          left_nxt = left_r - 8'd1;
          if (left_r == 8'd1) begin
            commit    = 1'b1;
            phase_nxt = PH_LEN;
          end
        end
        default: phase_nxt = PH_LEN;
      endcase
    end
  end

  // commit a finished structure into the kept record
  always_comb begin
    kept_nxt = kept_r;
    if (commit) begin
      unique case (type_nxt)
        AD_ADDR: begin
          if (pos_nxt >= 8'd7) begin
            for (int k = 0; k < 6; k++) kept_nxt.addr[8*k +: 8] = stage_nxt[5-k];
            kept_nxt.atype = |(stage_nxt[6] & ATYPE_MASK);
            kept_nxt.flags[FLAG_ADDR] = 1'b1;
          end
        end
        AD_ROLE: begin
          if (pos_nxt >= 8'd1) begin
            kept_nxt.role = stage_nxt[0];
            kept_nxt.flags[FLAG_ROLE] = 1'b1;
          end
        end
        AD_APPEARANCE: begin
          if (pos_nxt >= 8'd2) begin
            kept_nxt.app = {stage_nxt[1], stage_nxt[0]};
            kept_nxt.flags[FLAG_APP] = 1'b1;
          end
        end
        AD_NAME_SHORT, AD_NAME_FULL: begin
          kept_nxt.name = '0;
          for (int k = 0; k < NAME_BYTES; k++) begin
            if (k < NAME_KEEP && k < int'(pos_nxt)) kept_nxt.name[8*k +: 8] = stage_nxt[k];
          end
          kept_nxt.nlen = (int'(pos_nxt) < NAME_KEEP) ? pos_nxt[4:0] : 5'(NAME_KEEP);
          kept_nxt.flags[FLAG_NAME] = 1'b1;
        end
        AD_CONFIRM: begin
          if (pos_nxt >= 8'd16) begin
            for (int k = 0; k < 16; k++) kept_nxt.conf[8*k +: 8] = stage_nxt[k];
            kept_nxt.flags[FLAG_CONF] = 1'b1;
          end
        end
        AD_RANDOM: begin
          if (pos_nxt >= 8'd16) begin
            for (int k = 0; k < 16; k++) kept_nxt.rnd[8*k +: 8] = stage_nxt[k];
            kept_nxt.flags[FLAG_RND] = 1'b1;
          end
        end
        default: kept_nxt = kept_r;
      endcase
    end
  end

  always_comb begin
    load.valid = clear;
    load.data  = kept_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      phase_r <= PH_LEN;
      left_r  <= '0;
      type_r  <= '0;
      pos_r   <= '0;
      kept_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      type_r  <= type_nxt;
      pos_r   <= pos_nxt;
      kept_r  <= kept_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
  end

  `LEOOB_ASSERT_IMP(a_phase_onehot, 1'b1, $onehot(phase_r))
  `LEOOB_ASSERT_IMP(a_value_has_bytes, phase_r == PH_VALUE, left_r != 8'd0)
  `LEOOB_ASSERT_NXT(a_last_clears, clear, phase_r == PH_LEN && kept_r.flags == 6'd0)

endmodule

/* rtl/leoob_emit.sv */
// leoob_emit: snapshot buffer and nine-word result sequencer.
// Depends on leoob_pkg and le_oob_ad_parser_assert.svh.
`include "le_oob_ad_parser_assert.svh"

module leoob_emit import leoob_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  snap_load_t       load,
  output logic             load_free,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_kind,
  output logic [1:0]       out_word_index,
  output logic [63:0]      out_word,
  output logic [5:0]       out_present_flags,
  output logic             out_address_type,
  output logic [7:0]       out_role,
  output logic [15:0]      out_appearance,
  output logic [4:0]       out_name_length,
  output logic             out_last_result
);

  typedef enum logic [1:0] {
    KIND_ADDR = 2'd0,
    KIND_NAME = 2'd1,
    KIND_CONF = 2'd2,
    KIND_RND  = 2'd3
  } kind_t;

  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_WORDS - 1);

  logic             full_r;
  logic [CNT_W-1:0] cnt_r;
  kept_t            snap_r;
  logic             word_take;
  logic             run_done;
  kind_t            kind;

  assign word_take = full_r && out_ready;
  assign run_done  = word_take && (cnt_r == LAST_CNT);
  assign load_free = !full_r || run_done;
  assign out_valid = full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else if (load.valid) begin
      full_r <= 1'b1;
      cnt_r  <= '0;
    end else if (run_done) begin
      full_r <= 1'b0;
      cnt_r  <= '0;
    end else if (word_take) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load.valid) snap_r <= load.data;
  end

  // select the word for the current count
  always_comb begin
    kind           = KIND_ADDR;
    out_word_index = 2'd0;
    out_word       = '0;
    unique case (cnt_r)
      4'd0: out_word = {16'h0000, snap_r.addr};
      4'd1: begin kind = KIND_NAME; out_word_index = 2'd0; out_word = snap_r.name[63:0];    end
      4'd2: begin kind = KIND_NAME; out_word_index = 2'd1; out_word = snap_r.name[127:64];  end
      4'd3: begin kind = KIND_NAME; out_word_index = 2'd2; out_word = snap_r.name[191:128]; end
      4'd4: begin kind = KIND_NAME; out_word_index = 2'd3; out_word = snap_r.name[255:192]; end
      4'd5: begin kind = KIND_CONF; out_word_index = 2'd0; out_word = snap_r.conf[63:0];    end
      4'd6: begin kind = KIND_CONF; out_word_index = 2'd1; out_word = snap_r.conf[127:64];  end
      4'd7: begin kind = KIND_RND;  out_word_index = 2'd0; out_word = snap_r.rnd[63:0];     end
      4'd8: begin kind = KIND_RND;  out_word_index = 2'd1; out_word = snap_r.rnd[127:64];   end
      default: out_word = '0;
    endcase
  end

  assign out_kind          = kind;
  assign out_present_flags = snap_r.flags;
  assign out_address_type  = snap_r.atype;
  assign out_role          = snap_r.role;
  assign out_appearance    = snap_r.app;
  assign out_name_length   = snap_r.nlen;
  assign out_last_result   = (cnt_r == LAST_CNT);

  `LEOOB_ASSERT_IMP(a_cnt_range, full_r, cnt_r <= LAST_CNT)
  `LEOOB_ASSERT_IMP(a_no_overrun, load.valid && full_r, run_done)
  `LEOOB_ASSERT_NXT(a_drain, run_done && !load.valid, !full_r)
  `LEOOB_ASSERT_NXT(a_cnt_step, word_take && !run_done && !load.valid, cnt_r == $past(cnt_r) + CNT_W'(1))

endmodule

/* rtl/le_oob_ad_parser.sv */
// le_oob_ad_parser: top level of the LE OOB AD-structure parser.
// Depends on leoob_pkg, leoob_parse and leoob_emit.
//
// Usage:
//   Input channel (in_valid/in_ready): one payload byte per word, in_last_byte
//   marks a record's final byte. Bytes are taken one per cycle while in_ready.
//   Output channel (out_valid/out_ready): each record produces nine words in
//   order: address, name 0..3, confirm 0..1, random 0..1. Every word repeats
//   the scalar fields and presence flags; out_last_result marks the ninth.
//   Latency: the first word is valid the cycle after the last byte is taken;
//   the nine words then leave at one per cycle while the receiver is ready.
//   Throughput: one byte per cycle. The record is copied into a snapshot
//   buffer, so the next record's bytes are taken while words drain. A last
//   byte is held off (in_ready low) only while the previous run has not yet
//   delivered its final word; other bytes are never held.
//   Receiver stall: out_valid and the current word hold until out_ready.
//   Reset (rst_n low, synchronous): the parser expects a length byte, all
//   kept items and flags clear, and no word is pending.
//   After each record the parser returns to that same cleared state.

module le_oob_ad_parser import leoob_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_word_index,
  output logic [63:0] out_word,
  output logic [5:0]  out_present_flags,
  output logic        out_address_type,
  output logic [7:0]  out_role,
  output logic [15:0] out_appearance,
  output logic [4:0]  out_name_length,
  output logic        out_last_result
);

  snap_load_t load;
  logic       load_free;
  logic       byte_take;

  // hold a last byte only while the snapshot buffer is still busy
  assign in_ready  = !in_last_byte || load_free;
  assign byte_take = in_valid && in_ready;

  leoob_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_take (byte_take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .load      (load)
  );

  leoob_emit u_emit (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (load),
    .load_free         (load_free),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_kind          (out_kind),
    .out_word_index    (out_word_index),
    .out_word          (out_word),
    .out_present_flags (out_present_flags),
    .out_address_type  (out_address_type),
    .out_role          (out_role),
    .out_appearance    (out_appearance),
    .out_name_length   (out_name_length),
    .out_last_result   (out_last_result)
  );

endmodule
